/* hdl/scpt_pkg.sv */
// Shared types and constants of the segment and convex polygon test block.
package scpt_pkg;

    localparam int COORD_W      = 16;
    localparam int SLOT_W       = 4;
    localparam int VCOUNT_W     = 5;
    localparam int CMD_W        = 2;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int MAX_VERTICES = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEGMENT = 2'd2;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [SLOT_W-1:0]         vertex_slot;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } t_in_req;

    typedef struct packed {
        logic hit;
        logic was_segment;
    } t_out_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        SGN_NEG,
        SGN_ZERO,
        SGN_POS
    } t_sign;

endpackage

/* hdl/segment_convex_polygon_test_top.sv */
// Convex polygon store with point containment and segment intersection queries.
// A query over n vertices reads the vertex memory n+1 times (the last read wraps to vertex 0)
// and then drains the edge pipeline before its result is posted; a query with no vertices skips
// the reads. The next request is taken once the result is posted, and a query takes longer
// while an earlier result still waits in the result register.
// Reset is synchronous and clears the vertex count, the control state and the result valid.
module segment_convex_polygon_test_top #(
    parameter int MAX_VERTICES = scpt_pkg::MAX_VERTICES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  scpt_pkg::t_in_req                   i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output scpt_pkg::t_out_res                  o_out_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scpt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [scpt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [scpt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW     = scpt_pkg::COORD_W;
    localparam int MW     = 2 * CW;            // one memory word holds {x, y}
    localparam int DW     = CW + 1;            // coordinate differences
    localparam int PW     = 2 * DW;            // cross product terms
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VC_W   = scpt_pkg::VCOUNT_W;
    localparam int CMP_W  = (CNT_W > VC_W) ? CNT_W : VC_W;
    localparam logic [CMP_W-1:0] MAXV = CMP_W'(MAX_VERTICES);

    // ------------------------------------------------------------------
    // Configuration port. Only the vertex count register exists; the
    // word address is paddr[2], and writes to other words are dropped.
    // ------------------------------------------------------------------
    logic [VC_W-1:0] r_vertex_count;
    logic            w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (w_cfg_write && (paddr[2] == scpt_pkg::REG_VERTEX_COUNT)) begin
            r_vertex_count <= pwdata[VC_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == scpt_pkg::REG_VERTEX_COUNT) begin
            prdata = scpt_pkg::APB_DATA_W'(r_vertex_count);
        end else begin
            prdata = '0;
        end
    end

    // A count above the table depth is used as the table depth.
    logic [CMP_W-1:0] w_count_ext;
    logic [CNT_W-1:0] w_n;

    assign w_count_ext = CMP_W'(r_vertex_count);
    assign w_n = (w_count_ext > MAXV) ? CNT_W'(MAXV) : CNT_W'(w_count_ext);

    // ------------------------------------------------------------------
    // Request decode.
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_is_load;
    logic w_is_query;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_load  = i_in_req.command == scpt_pkg::CMD_LOAD;
    assign w_is_query = (i_in_req.command == scpt_pkg::CMD_POINT)
                     || (i_in_req.command == scpt_pkg::CMD_SEGMENT);

    // ------------------------------------------------------------------
    // Sequencer: walks the vertex memory once per query and waits for
    // the edge pipeline to empty before the result is posted.
    // ------------------------------------------------------------------
    scpt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_n;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_pipe_busy;
    logic             w_out_free;
    logic             w_post;

    logic r_rd_valid, r_rd_edge;
    logic r_e1_valid, r_e2_valid, r_e3_valid;
    logic r_out_valid;

    assign w_pipe_busy = r_rd_valid || r_e1_valid || r_e2_valid || r_e3_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;
    // The last read of a query wraps back to vertex 0 to close the polygon.
    assign w_rd_addr   = (r_cnt == r_n) ? '0 : IDX_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scpt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_post     = 1'b0;
        unique case (r_state)
            scpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && w_is_query) begin
                    n_cnt = '0;
                    // With no vertices the answer is known at once.
                    n_state = (w_n == '0) ? scpt_pkg::ST_DRAIN : scpt_pkg::ST_RUN;
                end
            end
            scpt_pkg::ST_RUN: begin
                w_rd_en = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == r_n) begin
                    n_state = scpt_pkg::ST_DRAIN;
                end
            end
            scpt_pkg::ST_DRAIN: begin
                if (!w_pipe_busy && w_out_free) begin
                    w_post  = 1'b1;
                    n_state = scpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scpt_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Vertex memory: one write port for loads, one registered read port.
    // Loads are only taken while idle, so reads and writes never overlap.
    // ------------------------------------------------------------------
    logic [MW-1:0]    r_mem [MAX_VERTICES];
    logic [MW-1:0]    r_rd_data;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;

    assign w_wr_en   = w_accept && w_is_load && (int'(i_in_req.vertex_slot) < MAX_VERTICES);
    assign w_wr_addr = IDX_W'(i_in_req.vertex_slot);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {i_in_req.first_x, i_in_req.first_y};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Query operands, latched at acceptance. c is the query point or the
    // segment start, d the segment end, f = d - c.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_cx, r_cy, r_dx, r_dy;
    logic signed [DW-1:0] r_fx, r_fy;
    logic                 r_is_seg;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_query) begin
            r_cx     <= i_in_req.first_x;
            r_cy     <= i_in_req.first_y;
            r_dx     <= i_in_req.second_x;
            r_dy     <= i_in_req.second_y;
            r_fx     <= DW'(i_in_req.second_x) - DW'(i_in_req.first_x);
            r_fy     <= DW'(i_in_req.second_y) - DW'(i_in_req.first_y);
            r_is_seg <= i_in_req.command == scpt_pkg::CMD_SEGMENT;
        end
    end

    // ------------------------------------------------------------------
    // Edge pipeline. Each edge a -> b gives four orientations:
    //   s1 = (b-a) x (c-a), s2 = (b-a) x (d-a),
    //   s3 = (d-c) x (a-c), s4 = (d-c) x (b-c).
    // s1 and s2 also serve the containment tests of c and d.
    // ------------------------------------------------------------------
    function automatic scpt_pkg::t_sign f_sign(input logic signed [PW-1:0] p,
                                               input logic signed [PW-1:0] q);
        if (p > q) begin
            return scpt_pkg::SGN_POS;
        end else if (p < q) begin
            return scpt_pkg::SGN_NEG;
        end
        return scpt_pkg::SGN_ZERO;
    endfunction

    function automatic logic f_in_box(input logic signed [CW-1:0] ax,
                                      input logic signed [CW-1:0] ay,
                                      input logic signed [CW-1:0] bx,
                                      input logic signed [CW-1:0] by,
                                      input logic signed [CW-1:0] px,
                                      input logic signed [CW-1:0] py);
        logic in_x;
        logic in_y;
        in_x = ((ax <= px) && (px <= bx)) || ((bx <= px) && (px <= ax));
        in_y = ((ay <= py) && (py <= by)) || ((by <= py) && (py <= ay));
        return in_x && in_y;
    endfunction

    function automatic logic f_opposite(input scpt_pkg::t_sign sa,
                                        input scpt_pkg::t_sign sb);
        return ((sa == scpt_pkg::SGN_POS) && (sb == scpt_pkg::SGN_NEG))
            || ((sa == scpt_pkg::SGN_NEG) && (sb == scpt_pkg::SGN_POS));
    endfunction

    logic [MW-1:0]        r_prev;
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;

    assign w_ax = r_prev[MW-1:CW];
    assign w_ay = r_prev[CW-1:0];
    assign w_bx = r_rd_data[MW-1:CW];
    assign w_by = r_rd_data[CW-1:0];

    // Stage 1: endpoints and differences.
    logic signed [CW-1:0] r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [DW-1:0] r1_ex, r1_ey, r1_cax, r1_cay, r1_dax, r1_day;
    logic signed [DW-1:0] r1_acx, r1_acy, r1_bcx, r1_bcy;
    // Stage 2: cross product terms and bounding box checks.
    logic signed [PW-1:0] r2_p1a, r2_p1b, r2_p2a, r2_p2b;
    logic signed [PW-1:0] r2_p3a, r2_p3b, r2_p4a, r2_p4b;
    logic                 r2_box_c, r2_box_d, r2_box_a, r2_box_b;
    // Stage 3: orientation signs.
    scpt_pkg::t_sign      r3_s1, r3_s2, r3_s3, r3_s4;
    logic                 r3_box_c, r3_box_d, r3_box_a, r3_box_b;
    // Running answers of the current query.
    logic                 r_in_c, r_in_d, r_touch;
    logic                 w_edge_touch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_edge  <= 1'b0;
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
            r_e3_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_rd_en;
            r_rd_edge  <= w_rd_en && (r_cnt != '0);
            r_e1_valid <= r_rd_edge;
            r_e2_valid <= r_e1_valid;
            r_e3_valid <= r_e2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_prev <= r_rd_data;
        end
        if (r_rd_edge) begin
            r1_ax  <= w_ax;
            r1_ay  <= w_ay;
            r1_bx  <= w_bx;
            r1_by  <= w_by;
            r1_ex  <= DW'(w_bx) - DW'(w_ax);
            r1_ey  <= DW'(w_by) - DW'(w_ay);
            r1_cax <= DW'(r_cx) - DW'(w_ax);
            r1_cay <= DW'(r_cy) - DW'(w_ay);
            r1_dax <= DW'(r_dx) - DW'(w_ax);
            r1_day <= DW'(r_dy) - DW'(w_ay);
            r1_acx <= DW'(w_ax) - DW'(r_cx);
            r1_acy <= DW'(w_ay) - DW'(r_cy);
            r1_bcx <= DW'(w_bx) - DW'(r_cx);
            r1_bcy <= DW'(w_by) - DW'(r_cy);
        end
        if (r_e1_valid) begin
            r2_p1a   <= r1_ex * r1_cay;
            r2_p1b   <= r1_ey * r1_cax;
            r2_p2a   <= r1_ex * r1_day;
            r2_p2b   <= r1_ey * r1_dax;
            r2_p3a   <= r_fx * r1_acy;
            r2_p3b   <= r_fy * r1_acx;
            r2_p4a   <= r_fx * r1_bcy;
            r2_p4b   <= r_fy * r1_bcx;
            r2_box_c <= f_in_box(r1_ax, r1_ay, r1_bx, r1_by, r_cx, r_cy);
            r2_box_d <= f_in_box(r1_ax, r1_ay, r1_bx, r1_by, r_dx, r_dy);
            r2_box_a <= f_in_box(r_cx, r_cy, r_dx, r_dy, r1_ax, r1_ay);
            r2_box_b <= f_in_box(r_cx, r_cy, r_dx, r_dy, r1_bx, r1_by);
        end
        if (r_e2_valid) begin
            r3_s1    <= f_sign(r2_p1a, r2_p1b);
            r3_s2    <= f_sign(r2_p2a, r2_p2b);
            r3_s3    <= f_sign(r2_p3a, r2_p3b);
            r3_s4    <= f_sign(r2_p4a, r2_p4b);
            r3_box_c <= r2_box_c;
            r3_box_d <= r2_box_d;
            r3_box_a <= r2_box_a;
            r3_box_b <= r2_box_b;
        end
        // An empty product over no edges leaves both points inside.
        if (w_accept && w_is_query) begin
            r_in_c  <= 1'b1;
            r_in_d  <= 1'b1;
            r_touch <= 1'b0;
        end else if (r_e3_valid) begin
            r_in_c  <= r_in_c && (r3_s1 == scpt_pkg::SGN_NEG);
            r_in_d  <= r_in_d && (r3_s2 == scpt_pkg::SGN_NEG);
            r_touch <= r_touch || w_edge_touch;
        end
    end

    // A proper crossing, or an endpoint on the other's line within its box.
    assign w_edge_touch = (f_opposite(r3_s1, r3_s2) && f_opposite(r3_s3, r3_s4))
                       || ((r3_s1 == scpt_pkg::SGN_ZERO) && r3_box_c)
                       || ((r3_s2 == scpt_pkg::SGN_ZERO) && r3_box_d)
                       || ((r3_s3 == scpt_pkg::SGN_ZERO) && r3_box_a)
                       || ((r3_s4 == scpt_pkg::SGN_ZERO) && r3_box_b);

    // ------------------------------------------------------------------
    // Result register. A finished result waits here while the next
    // request is taken; the sequencer only posts into a free slot.
    // ------------------------------------------------------------------
    scpt_pkg::t_out_res r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_post) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            r_out_res.hit         <= r_is_seg ? (r_in_c || r_in_d || r_touch) : r_in_c;
            r_out_res.was_segment <= r_is_seg;
        end
    end

    // The edge count of a query is latched with the query.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_query) begin
            r_n <= w_n;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_rd_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (int'(w_rd_addr) < MAX_VERTICES))
        else $error("vertex read address beyond table");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scpt_pkg::ST_IDLE) |-> !w_pipe_busy)
        else $error("edge pipeline busy while idle");

    a_post_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == scpt_pkg::ST_DRAIN))
        else $error("result posted outside drain");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scpt_pkg::ST_RUN) |-> (r_cnt <= r_n))
        else $error("read counter ran past the edge count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_out_res) && r_out_valid))
        else $error("pending result lost or changed");

endmodule
